// ===== src/tbrl_pkg.sv =====
// Shared widths, constants, status codes and beat types of the token bucket rate limiter.
package tbrl_pkg;

  // Field and state widths
  localparam int BURST_W  = 16;
  localparam int RATE_W   = 20;
  localparam int TIME_W   = 64;
  localparam int COST_W   = 16;
  localparam int STATUS_W = 2;
  localparam int WHOLE_W  = 16;
  localparam int FRAC_W   = 20;
  localparam int CREDIT_W = 37;
  localparam int PROD_W   = 38;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // Credit units in one whole token
  localparam int UNITS_PER_TOKEN = 1000000;

  // Item operations
  localparam logic OP_CONSUME = 1'b0;
  localparam logic OP_RESET   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOWED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LIMITED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REGRESSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADCOST   = 2'd3;

  // Register indexes (word index, paddr[2])
  localparam logic REG_BURST = 1'b0;
  localparam logic REG_RATE  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] now_us;
    logic [COST_W-1:0] cost;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WHOLE_W-1:0]  whole_tokens;
    logic [FRAC_W-1:0]   fraction_units;
  } out_item_t;

endpackage

// ===== src/token_bucket_rate_limiter.sv =====
// Token bucket rate limiter: sequencer with serial refill multiplier and serial divider.
//
// Usage: software writes the bucket depth (address 0) and the refill rate (address 4)
// through the APB-style port, then sends a reset item to fill the bucket. Each input
// beat on in_valid/in_ready is a consume request or a reset carrying a microsecond
// timestamp; each produces exactly one result beat on out_valid/out_ready with a status
// and the credit left, as whole tokens and a fractional remainder.
// In order, a consume that refills passes a check step, the shift-add multiplier (elapsed
// time times rate, one rate bit per cycle), a step to cap the refill and one to debit,
// a load step, the restoring divider that splits the credit (one quotient bit per
// cycle) and a last step that loads the result. A reset, a zero-cost consume or a
// consume refused on the clock check skips the multiplier, the cap and the debit. The
// next beat is accepted in the cycle after the result is loaded.
// The result sits in an output register: a new beat is accepted and worked on while the
// previous result waits for out_ready; a finished result waits in its last step until
// the output register frees.
// Reset (rst_n low, synchronous) clears the registers, the credit, the refill time and
// the clock-regressed flag; the bucket capacity is zero until configured.
module token_bucket_rate_limiter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tbrl_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tbrl_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbrl_pkg::ADDR_W-1:0] paddr,
  input  logic [tbrl_pkg::DATA_W-1:0] pwdata,
  output logic [tbrl_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tbrl_pkg::*;

  localparam int CNT_W = $clog2(RATE_W > WHOLE_W ? RATE_W : WHOLE_W);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(RATE_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WHOLE_W - 1);
  localparam logic [CREDIT_W-1:0] UNITS = CREDIT_W'(UNITS_PER_TOKEN);
  localparam logic [CREDIT_W-1:0] DV_INIT = UNITS << (WHOLE_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_REFILL,
    S_DEBIT,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [BURST_W-1:0]    burst_r;
  logic [RATE_W-1:0]     rate_r;
  logic [CREDIT_W-1:0]   cap_r;
  logic [CREDIT_W-1:0]   credit_r;
  logic [TIME_W-1:0]     last_r;
  logic                  flag_r;
  logic                  op_r;
  logic [TIME_W-1:0]     now_r;
  logic [COST_W-1:0]     cost_r;
  logic [CREDIT_W-1:0]   need_r;
  logic [STATUS_W-1:0]   status_r;
  logic [CREDIT_W-1:0]   mcand_r;
  logic [RATE_W-1:0]     mplier_r;
  logic [PROD_W-1:0]     prod_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CREDIT_W-1:0]   rem_r;
  logic [CREDIT_W-1:0]   dv_r;
  logic [WHOLE_W-1:0]    quo_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic                  cfg_wr;
  logic [TIME_W:0]       diff;
  logic [CREDIT_W-1:0]   elapsed_sat;
  logic [PROD_W+1:0]     mul_sum;
  logic [PROD_W-1:0]     prod_nxt;
  logic [CREDIT_W+1:0]   refill_sum;
  logic [CREDIT_W-1:0]   refill_nxt;
  logic [CREDIT_W-1:0]   cap_nxt;
  logic [CREDIT_W-1:0]   need_nxt;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Read back the configuration registers
  always_comb begin
    unique case (paddr[2])
      REG_BURST: prdata = {{(DATA_W-BURST_W){1'b0}}, burst_r};
      REG_RATE:  prdata = {{(DATA_W-RATE_W){1'b0}}, rate_r};
      default:   prdata = '0;
    endcase
  end

  // Capacity and debit in credit units
  assign cap_nxt  = {{(CREDIT_W-BURST_W){1'b0}}, burst_r} * UNITS;
  assign need_nxt = {{(CREDIT_W-COST_W){1'b0}}, cost_r} * UNITS;

  // Elapsed time, saturated where any product would overflow the capacity anyway
  assign diff        = {1'b0, now_r} - {1'b0, last_r};
  assign elapsed_sat = (|diff[TIME_W-1:CREDIT_W]) ? '1 : diff[CREDIT_W-1:0];

  // One shift-add step of elapsed times rate, saturating at all ones
  assign mul_sum  = {1'b0, prod_r, 1'b0} +
                    (mplier_r[RATE_W-1] ? {{(PROD_W+2-CREDIT_W){1'b0}}, mcand_r} : '0);
  assign prod_nxt = (|mul_sum[PROD_W+1:PROD_W]) ? '1 : mul_sum[PROD_W-1:0];

  // Refill capped at the capacity
  assign refill_sum = {2'b00, credit_r} + {1'b0, prod_r};
  assign refill_nxt = (refill_sum > {2'b00, cap_r}) ? cap_r : refill_sum[CREDIT_W-1:0];

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      burst_r     <= '0;
      rate_r      <= '0;
      cap_r       <= '0;
      credit_r    <= '0;
      last_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_BURST: burst_r <= pwdata[BURST_W-1:0];
          REG_RATE:  rate_r  <= pwdata[RATE_W-1:0];
          default:   ;
        endcase
      end
      cap_r <= cap_nxt;

      // Drop the result beat once taken; the last step reloads it instead
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_data.op;
            now_r   <= in_data.now_us;
            cost_r  <= in_data.cost;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          need_r <= need_nxt;
          if (op_r == OP_RESET) begin
            last_r   <= now_r;
            credit_r <= cap_r;
            flag_r   <= 1'b0;
            status_r <= ST_ALLOWED;
            state_r  <= S_LOAD;
          end else if (cost_r == '0) begin
            status_r <= ST_BADCOST;
            state_r  <= S_LOAD;
          end else if (flag_r) begin
            status_r <= ST_REGRESSED;
            state_r  <= S_LOAD;
          end else if (diff[TIME_W]) begin
            flag_r   <= 1'b1;
            status_r <= ST_REGRESSED;
            state_r  <= S_LOAD;
          end else begin
            last_r   <= now_r;
            mcand_r  <= elapsed_sat;
            mplier_r <= rate_r;
            prod_r   <= '0;
            cnt_r    <= '0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          // Advance one rate bit, most significant first
          prod_r   <= prod_nxt;
          mplier_r <= {mplier_r[RATE_W-2:0], 1'b0};
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == MUL_LAST) begin
            state_r <= S_REFILL;
          end
        end
        S_REFILL: begin
          credit_r <= refill_nxt;
          state_r  <= S_DEBIT;
        end
        S_DEBIT: begin
          if (need_r > credit_r) begin
            status_r <= ST_LIMITED;
          end else begin
            credit_r <= credit_r - need_r;
            status_r <= ST_ALLOWED;
          end
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          rem_r   <= credit_r;
          dv_r    <= DV_INIT;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // Restore one quotient bit per cycle
          if (rem_r >= dv_r) begin
            rem_r <= rem_r - dv_r;
            quo_r <= {quo_r[WHOLE_W-2:0], 1'b1};
          end else begin
            quo_r <= {quo_r[WHOLE_W-2:0], 1'b0};
          end
          dv_r  <= dv_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_r.status         <= status_r;
            out_r.whole_tokens   <= quo_r;
            out_r.fraction_units <= rem_r[FRAC_W-1:0];
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Refilled credit never exceeds the capacity
  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEBIT) |-> (credit_r <= cap_r))
    else $error("credit above capacity after refill");

  // The remainder reported stays below one token
  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.fraction_units < UNITS[FRAC_W-1:0]))
    else $error("fraction at or above one token");

  // An accepted beat goes straight to the check step
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK))
    else $error("accepted beat not checked");

  // The regressed flag rises only from a failed clock check
  a_flag_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(flag_r) |-> ($past(state_r) == S_CHECK && $past(op_r) == OP_CONSUME))
    else $error("clock-regressed flag set outside the clock check");

endmodule

// ===== verif/tbrl_credit_checker.sv =====
// Checker for the token bucket rate limiter: tracks register writes, predicts each result beat and compares.
`timescale 1ns / 1ps
module tbrl_credit_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  tbrl_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  tbrl_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [tbrl_pkg::ADDR_W-1:0] paddr,
  input  logic [tbrl_pkg::DATA_W-1:0] pwdata,
  output int                          fail_count,
  output int                          pending
);
  import tbrl_pkg::*;

  // Shadow registers and bucket state
  logic [BURST_W-1:0] burst_cfg;
  logic [RATE_W-1:0]  rate_cfg;
  longint unsigned    bucket_credit;
  longint unsigned    last_stamp;
  logic               clock_went_back;

  out_item_t owed_results[$];
  int        mism;

  // Apply one request to the bucket and return the status and credit it reports
  function automatic out_item_t predict_beat(input in_item_t req);
    longint unsigned units;
    longint unsigned cap;
    longint unsigned rate;
    longint unsigned elapsed;
    longint unsigned missing;
    longint unsigned need;
    out_item_t       res;
    units = UNITS_PER_TOKEN;
    cap   = longint'(burst_cfg) * units;
    rate  = longint'(rate_cfg);
    if (req.op == OP_RESET) begin
      last_stamp      = req.now_us;
      bucket_credit   = cap;
      clock_went_back = 1'b0;
      res.status      = ST_ALLOWED;
    end else if (req.cost == '0) begin
      // zero cost is refused before the clock is looked at
      res.status = ST_BADCOST;
    end else if (clock_went_back) begin
      res.status = ST_REGRESSED;
    end else if (req.now_us < last_stamp) begin
      clock_went_back = 1'b1;
      res.status      = ST_REGRESSED;
    end else begin
      // refill by elapsed time, clamp to capacity
      elapsed    = req.now_us - last_stamp;
      last_stamp = req.now_us;
      if (bucket_credit >= cap) begin
        bucket_credit = cap;
      end else if (elapsed != 0 && rate != 0) begin
        missing = cap - bucket_credit;
        if (elapsed >= (missing + rate - 1) / rate) begin
          bucket_credit = cap;
        end else begin
          bucket_credit = bucket_credit + elapsed * rate;
        end
      end
      // debit or refuse
      need = longint'(req.cost) * units;
      if (need > bucket_credit) begin
        res.status = ST_LIMITED;
      end else begin
        bucket_credit = bucket_credit - need;
        res.status    = ST_ALLOWED;
      end
    end
    res.whole_tokens   = WHOLE_W'(bucket_credit / units);
    res.fraction_units = FRAC_W'(bucket_credit % units);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      burst_cfg       = '0;
      rate_cfg        = '0;
      bucket_credit   = 0;
      last_stamp      = 0;
      clock_went_back = 1'b0;
      mism            = 0;
      owed_results.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_BURST: burst_cfg = pwdata[BURST_W-1:0];
          REG_RATE:  rate_cfg  = pwdata[RATE_W-1:0];
          default: ;
        endcase
      end

      // Compare each result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result beat: status %0d whole %0d fraction %0d",
                 out_data.status, out_data.whole_tokens, out_data.fraction_units);
          mism++;
        end else begin
          want = owed_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mism++;
          end
          if (out_data.whole_tokens !== want.whole_tokens) begin
            $error("whole_tokens: expected %0d, got %0d",
                   want.whole_tokens, out_data.whole_tokens);
            mism++;
          end
          if (out_data.fraction_units !== want.fraction_units) begin
            $error("fraction_units: expected %0d, got %0d",
                   want.fraction_units, out_data.fraction_units);
            mism++;
          end
        end
      end

      // Predict the result of each accepted request beat
      if (in_valid && in_ready) begin
        owed_results.push_back(predict_beat(in_data));
      end
    end
    fail_count <= mism;
    pending    <= owed_results.size();
  end

endmodule

// ===== verif/tb_token_bucket_rate_limiter.sv =====
// Testbench top for the token bucket rate limiter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_token_bucket_rate_limiter;
  import tbrl_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_TICKS = 50;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 190;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data  = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  out_item_t         out_data;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b1;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int              fail_count;
  int              pending;
  int              gap_pct    = 0;
  int              stall_pct  = 0;
  logic            calm       = 1'b0;
  int              stall_left = 0;
  int              cycles     = 0;
  longint unsigned clock_us   = 0;

  token_bucket_rate_limiter dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tbrl_credit_checker credit_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("token_bucket_rate_limiter: mismatch");
      $finish;
    end
  end

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one request beat, maybe after a gap, and hold it until accepted
  task automatic offer(input logic op, input longint unsigned now,
                       input logic [COST_W-1:0] cost);
    in_item_t beat;
    beat.op     = op;
    beat.now_us = now;
    beat.cost   = cost;
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram both registers while idle; junk in the unused upper bits
  task automatic configure(input logic [BURST_W-1:0] burst, input logic [RATE_W-1:0] rate);
    drain();
    write_reg(REG_BURST, {16'($urandom), burst});
    write_reg(REG_RATE, {12'($urandom), rate});
  endtask

  initial begin
    logic [BURST_W-1:0] burst;
    logic [RATE_W-1:0]  rate;
    logic [COST_W-1:0]  cost;
    longint unsigned    step;
    int                 pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still at reset: zero capacity
    offer(OP_CONSUME, 64'd5, 16'd1);
    offer(OP_RESET, 64'd0, 16'd7);

    // Half a token per microsecond, ten tokens deep
    configure(16'd10, 20'd500000);
    offer(OP_RESET, 64'd100, 16'd0);
    offer(OP_CONSUME, 64'd100, 16'd3);      // no time passed
    offer(OP_CONSUME, 64'd100, 16'd0);      // zero cost
    offer(OP_CONSUME, 64'd101, 16'd20);     // more than the bucket holds
    offer(OP_CONSUME, 64'd104, 16'd1);      // partial refill
    offer(OP_CONSUME, 64'd1000, 16'hFFFF);  // refill clamps at capacity
    offer(OP_CONSUME, 64'd50, 16'd1);       // time goes backwards
    offer(OP_CONSUME, 64'd2000, 16'd1);     // flag stays set
    offer(OP_CONSUME, 64'd2000, 16'd0);     // zero cost wins over the flag
    offer(OP_RESET, 64'd2000, 16'hFFFF);
    offer(OP_CONSUME, 64'd2000, 16'd10);    // empty the bucket
    offer(OP_CONSUME, 64'd2001, 16'd1);
    offer(OP_RESET, 64'd3000, 16'd1);

    // Shrink the bucket without a reset, stop the refill
    configure(16'd3, 20'd0);
    offer(OP_CONSUME, 64'd3001, 16'd1);
    offer(OP_CONSUME, 64'd5000, 16'd1);

    // Widest bucket, rate above its nominal range, time at the very top
    configure(16'hFFFF, 20'hFFFFF);
    offer(OP_RESET, 64'hFFFF_FFFF_FFFF_FFFE, 16'd0);
    offer(OP_CONSUME, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    offer(OP_CONSUME, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
    offer(OP_RESET, 64'd0, 16'hAAAA);
    offer(OP_CONSUME, 64'd0, 16'hFFFF);
    offer(OP_CONSUME, 64'd62500, 16'h5555);

    // Random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin burst = 16'd1; rate = 20'd1; end
        1: begin burst = 16'hFFFF; rate = 20'd1000000; end
        2: begin burst = 16'd0; rate = RATE_W'($urandom_range(1, 20'hFFFFF)); end
        3: begin burst = BURST_W'($urandom_range(1, 64)); rate = 20'd0; end
        4: begin burst = BURST_W'($urandom_range(1, 16)); rate = 20'd1000000; end
        default: begin
          burst = BURST_W'($urandom_range(1, 200));
          rate  = RATE_W'($urandom_range(1, 20'hFFFFF) >> $urandom_range(0, 19));
        end
      endcase
      calm      <= (p == PHASES - 1);
      gap_pct   <= (p == 3 || p == PHASES - 1) ? 0 : $urandom_range(10, 40);
      stall_pct <= (p == 3 || p == PHASES - 1) ? 0 : $urandom_range(10, 40);
      configure(burst, rate);

      // One phase carries on from the previous bucket without a reset
      clock_us = {$urandom, $urandom} >> $urandom_range(0, 63);
      if (p != 5) offer(OP_RESET, clock_us, 16'($urandom));

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain();
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          if ($urandom_range(0, 2) == 0) clock_us = {$urandom, $urandom};
          offer(OP_RESET, clock_us, 16'($urandom));
        end else if (pick < 10) begin
          offer(OP_CONSUME, clock_us + $urandom_range(0, 100), '0);
        end else if (pick < 13 && clock_us != 0) begin
          // stale timestamp
          offer(OP_CONSUME, clock_us - 1 - ({$urandom, $urandom} % clock_us),
                16'($urandom_range(1, 4)));
        end else begin
          case ($urandom_range(0, 9))
            0, 1:    step = 0;
            2, 3, 4: step = $urandom_range(1, 8);
            5, 6:    step = $urandom_range(1, 2000);
            7, 8:    step = $urandom_range(1, 3000000);
            default: step = {$urandom, $urandom} >> $urandom_range(8, 63);
          endcase
          clock_us = clock_us + step;
          cost = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(1, 3));
          offer(OP_CONSUME, clock_us, cost);
        end
      end
    end

    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("token_bucket_rate_limiter: match");
    end else begin
      $display("token_bucket_rate_limiter: mismatch");
    end
    $finish;
  end

endmodule

// ===== token_bucket_rate_limiter.f =====
src/tbrl_pkg.sv
src/token_bucket_rate_limiter.sv
verif/tbrl_credit_checker.sv
verif/tb_token_bucket_rate_limiter.sv
